// ===== design/btpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for the barometric temperature and pressure
// compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_T1    = 3'd0,
        CFG_T2    = 3'd1,
        CFG_T3    = 3'd2,
        CFG_P1    = 3'd3,
        CFG_P2_P5 = 3'd4,
        CFG_P6_P9 = 3'd5
    } cfg_index_t;

    localparam int CFG_W         = 64;

    localparam int FRONT_STAGES  = 12;
    localparam int DIV_INT_STEPS = 12;   // integer quotient bits before saturation
    localparam int DIV_FRAC_BITS = 24;
    localparam int DIV_STEPS     = DIV_INT_STEPS + DIV_FRAC_BITS;
    localparam int BACK_STAGES   = 9;
    localparam int NUM_STAGES    = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

    localparam int REM_W = 62;           // magnitude of the scaled numerator
    localparam int DEN_W = 48;           // magnitude of the divisor
    localparam int QUO_W = DIV_STEPS;

    localparam logic signed [24:0] T_FINE_OFFSET = 25'sd128000;
    localparam logic signed [21:0] PRES_FULL     = 22'sd1048576;
    localparam logic signed [63:0] C_BIAS        = 64'sh0080_0000_0000_0000;
    localparam logic signed [61:0] PA_SCALE      = 62'sd6250;
    localparam logic [39:0]        RECIP_TEN     = 40'd838861;  // ceil(2^23 / 10)
    localparam logic [29:0]        PRES_SAT_PA   = 30'd655360;  // 65536 * 10 Pa

    typedef struct packed {
        logic signed [15:0] temp;
        logic               neg;
        logic               inv;
        logic               ovf;
    } side_t;

endpackage

// ===== design/baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Fixed-point calibration polynomial for a barometric sensor: raw 20-bit
// temperature and pressure in, 0.1 degC and 0.1 hPa out.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six calibration registers through cfg_wr_en / cfg_index /
//   cfg_wdata while no request is in flight. Each request on the s_axis
//   channel carries one raw temperature and one raw pressure reading and
//   produces exactly one result on the m_axis channel, in order.
//   An accepted request reaches a valid result by passing through
//   12 stages of polynomial work, a 36-stage restoring divider (one quotient
//   bit per stage) and 9 stages of pressure correction and scaling.
//   Throughput is one request per cycle unless stalled; the divider stages set the depth.
//   m_axis_tuser flags a zero divisor, in which case pressure reads 0.
//   Reset clears all valid bits and the calibration words to zero.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline freezes and s_axis_tready drops; nothing is lost or
//   repeated. While no result is waiting the pipeline keeps advancing
//   whatever m_axis_tready does.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [39:0]      s_axis_tdata,   // raw_temp[19:0], raw_pres[39:20]

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // temp_tenths_c[15:0], pres_tenths_hpa[31:16]
    output logic             m_axis_tuser    // pres_invalid[0]
);

    // ------------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------------
    logic [15:0] cal_t1_reg, cal_t2_reg, cal_t3_reg, cal_p1_reg;
    logic [63:0] cal_p25_reg, cal_p69_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_t1_reg  <= '0;
            cal_t2_reg  <= '0;
            cal_t3_reg  <= '0;
            cal_p1_reg  <= '0;
            cal_p25_reg <= '0;
            cal_p69_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_T1:    cal_t1_reg  <= cfg_wdata[15:0];
                CFG_T2:    cal_t2_reg  <= cfg_wdata[15:0];
                CFG_T3:    cal_t3_reg  <= cfg_wdata[15:0];
                CFG_P1:    cal_p1_reg  <= cfg_wdata[15:0];
                CFG_P2_P5: cal_p25_reg <= cfg_wdata;
                CFG_P6_P9: cal_p69_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t2 = $signed(cal_t2_reg);
    assign t3 = $signed(cal_t3_reg);
    assign p2 = $signed(cal_p25_reg[15:0]);
    assign p3 = $signed(cal_p25_reg[31:16]);
    assign p4 = $signed(cal_p25_reg[47:32]);
    assign p5 = $signed(cal_p25_reg[63:48]);
    assign p6 = $signed(cal_p69_reg[15:0]);
    assign p7 = $signed(cal_p69_reg[31:16]);
    assign p8 = $signed(cal_p69_reg[47:32]);
    assign p9 = $signed(cal_p69_reg[63:48]);

    // ------------------------------------------------------------------------
    // flow control: the whole pipeline advances unless a result is stuck
    // ------------------------------------------------------------------------
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  en;

    assign en            = !vld_reg[NUM_STAGES-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_axis_tvalid};
        end
    end

    // ------------------------------------------------------------------------
    // front stages: temperature, fine temperature, divisor and numerator
    // ------------------------------------------------------------------------
    logic signed [21:0] d_reg;
    logic signed [37:0] m1_reg;
    logic signed [43:0] dd_reg;
    logic signed [59:0] s_reg;
    logic signed [23:0] tfine_reg;
    logic signed [24:0] a_reg;
    logic signed [49:0] aa_reg;
    logic signed [40:0] pa2_reg, p5a_reg, pa2_7_reg, p5a_7_reg;
    logic signed [61:0] p3aa_reg, p6aa_reg;
    logic signed [63:0] c_reg, n_reg;
    logic signed [31:0] cq_reg;
    logic signed [47:0] nq_reg;
    logic signed [48:0] den_reg;
    logic signed [61:0] x_reg;
    logic [REM_W-1:0]   xm_reg;
    logic [DEN_W-1:0]   dm_reg;
    logic               neg_reg, inv_reg;
    logic [19:0]        pres_pipe_reg [0:6];
    logic signed [15:0] temp_pipe_reg [0:7];

    logic signed [21:0] d_next;
    logic signed [59:0] s_next;
    logic signed [59:0] s_tf_sum, s_tc_sum;
    logic signed [21:0] pdiff;
    logic signed [63:0] c_next, n_next;

    logic [REM_W-1:0]  div_rem_reg  [0:DIV_STEPS];
    logic [DEN_W-1:0]  div_den_reg  [0:DIV_STEPS];
    logic [QUO_W-1:0]  div_quo_reg  [0:DIV_STEPS];
    side_t             div_side_reg [0:DIV_STEPS];

    always_comb begin
        d_next   = $signed({2'b00, s_axis_tdata[19:0]})
                 - $signed({2'b00, cal_t1_reg, 4'b0000});
        s_next   = (60'(m1_reg) <<< 20) + 60'(dd_reg) * 60'(t3);
        // bias negative values so the shifts truncate toward zero
        s_tf_sum = s_reg + $signed({26'd0, {34{s_reg[59]}}});
        s_tc_sum = s_reg + $signed({17'd0, {43{s_reg[59]}}});
        pdiff    = PRES_FULL - $signed({2'b00, pres_pipe_reg[6]});
        c_next   = C_BIAS + 64'(p3aa_reg) + (64'(pa2_7_reg) <<< 20);
        n_next   = (64'(pdiff) <<< 31) - 64'(p6aa_reg)
                 - (64'(p5a_7_reg) <<< 17) - (64'(p4) <<< 35);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            d_reg            <= d_next;
            pres_pipe_reg[0] <= s_axis_tdata[39:20];
            for (int k = 1; k < 7; k++) begin
                pres_pipe_reg[k] <= pres_pipe_reg[k-1];
            end
            // stage 2
            m1_reg <= 38'(d_reg) * 38'(t2);
            dd_reg <= 44'(d_reg) * 44'(d_reg);
            // stage 3
            s_reg  <= s_next;
            // stage 4: |s| stays below 2^56, so the temperature never clips
            tfine_reg        <= 24'(s_tf_sum >>> 34);
            temp_pipe_reg[0] <= 16'(s_tc_sum >>> 43);
            for (int k = 1; k < 8; k++) begin
                temp_pipe_reg[k] <= temp_pipe_reg[k-1];
            end
            // stage 5
            a_reg <= 25'(tfine_reg) - T_FINE_OFFSET;
            // stage 6
            aa_reg  <= 50'(a_reg) * 50'(a_reg);
            pa2_reg <= 41'(a_reg) * 41'(p2);
            p5a_reg <= 41'(a_reg) * 41'(p5);
            // stage 7
            p3aa_reg  <= 62'(aa_reg) * 62'(p3);
            p6aa_reg  <= 62'(aa_reg) * 62'(p6);
            pa2_7_reg <= pa2_reg;
            p5a_7_reg <= p5a_reg;
            // stage 8
            c_reg <= c_next;
            n_reg <= n_next;
            // stage 9
            cq_reg <= 32'((c_reg + $signed({32'd0, {32{c_reg[63]}}})) >>> 32);
            nq_reg <= 48'((n_reg + $signed({48'd0, {16{n_reg[63]}}})) >>> 16);
            // stage 10
            den_reg <= 49'($signed({1'b0, cal_p1_reg})) * 49'(cq_reg);
            x_reg   <= 62'(nq_reg) * PA_SCALE;
            // stage 11: split into sign and magnitudes
            neg_reg <= x_reg[61] ^ den_reg[48];
            inv_reg <= (den_reg == '0);
            xm_reg  <= x_reg[61] ? REM_W'(-x_reg) : REM_W'(x_reg);
            dm_reg  <= den_reg[48] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
            // stage 12: saturate when the integer quotient reaches 2^12
            div_rem_reg[0]       <= xm_reg;
            div_den_reg[0]       <= dm_reg;
            div_quo_reg[0]       <= '0;
            div_side_reg[0].temp <= temp_pipe_reg[7];
            div_side_reg[0].neg  <= neg_reg;
            div_side_reg[0].inv  <= inv_reg;
            div_side_reg[0].ovf  <= xm_reg >= {dm_reg, {DIV_INT_STEPS{1'b0}}};
        end
    end

    // ------------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------------
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [REM_W-1:0] base, trial;
        logic             ge;

        if (j < DIV_INT_STEPS) begin : g_int
            assign base  = div_rem_reg[j];
            assign trial = REM_W'(div_den_reg[j]) << (DIV_INT_STEPS - 1 - j);
        end else begin : g_frac
            assign base  = div_rem_reg[j] << 1;
            assign trial = REM_W'(div_den_reg[j]);
        end

        assign ge = base >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                div_rem_reg[j+1]  <= ge ? base - trial : base;
                div_den_reg[j+1]  <= div_den_reg[j];
                div_quo_reg[j+1]  <= {div_quo_reg[j][QUO_W-2:0], ge};
                div_side_reg[j+1] <= div_side_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // back stages: second-order correction and scaling to 0.1 hPa
    // ------------------------------------------------------------------------
    logic [36:0]        pmag;
    logic signed [37:0] pq_reg, pq_50_reg, pq_51_reg, pq_52_reg, pq_53_reg;
    logic [28:0]        hm_reg;
    logic [57:0]        hh_reg;
    logic signed [53:0] v2p_reg;
    logic signed [63:0] v1p_reg;
    logic signed [38:0] v2_reg, v2_52_reg;
    logic signed [42:0] v1_reg;
    logic signed [44:0] sum_reg;
    logic signed [45:0] f_reg;
    logic               fneg_reg, big_reg;
    logic               fneg_56_reg, big_56_reg;
    logic [19:0]        g_reg;
    logic [39:0]        prod_reg;
    side_t              post_side_reg [0:7];
    logic [15:0]        temp_out_reg, pres_out_reg;
    logic               inv_out_reg;
    logic [15:0]        pres_next;

    assign pmag = div_side_reg[DIV_STEPS].ovf ? 37'h10_0000_0000
                                              : {1'b0, div_quo_reg[DIV_STEPS]};

    always_comb begin
        if (post_side_reg[7].inv || fneg_56_reg) begin
            pres_next = '0;
        end else if (big_56_reg) begin
            pres_next = 16'hFFFF;
        end else begin
            pres_next = prod_reg[38:23];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 49: apply sign, take magnitude for the square
            pq_reg           <= div_side_reg[DIV_STEPS].neg ? -$signed({1'b0, pmag})
                                                            : $signed({1'b0, pmag});
            hm_reg           <= pmag[36:8];
            post_side_reg[0] <= div_side_reg[DIV_STEPS];
            for (int k = 1; k < 8; k++) begin
                post_side_reg[k] <= post_side_reg[k-1];
            end
            // stage 50
            hh_reg    <= 58'(hm_reg) * 58'(hm_reg);
            v2p_reg   <= 54'(pq_reg) * 54'(p8);
            pq_50_reg <= pq_reg;
            // stage 51
            v1p_reg   <= 64'($signed({1'b0, hh_reg[57:10]})) * 64'(p9);
            v2_reg    <= 39'((v2p_reg + $signed({39'd0, {15{v2p_reg[53]}}})) >>> 15);
            pq_51_reg <= pq_50_reg;
            // stage 52
            v1_reg    <= 43'((v1p_reg + $signed({43'd0, {21{v1p_reg[63]}}})) >>> 21);
            v2_52_reg <= v2_reg;
            pq_52_reg <= pq_51_reg;
            // stage 53
            sum_reg   <= 45'(v1_reg) + 45'(v2_52_reg) + (45'(p7) <<< 16);
            pq_53_reg <= pq_52_reg;
            // stage 54
            f_reg <= 46'(pq_53_reg)
                   + 46'((sum_reg + $signed({41'd0, {4{sum_reg[44]}}})) >>> 4);
            // stage 55: negative pressure clips to zero
            fneg_reg <= f_reg[45];
            big_reg  <= f_reg[45:16] >= PRES_SAT_PA;
            g_reg    <= f_reg[35:16];
            // stage 56: divide by ten through the reciprocal, hold the flags
            prod_reg    <= 40'(g_reg) * RECIP_TEN;
            fneg_56_reg <= fneg_reg;
            big_56_reg  <= big_reg;
            // stage 57
            temp_out_reg <= post_side_reg[7].temp;
            pres_out_reg <= pres_next;
            inv_out_reg  <= post_side_reg[7].inv;
        end
    end

    assign m_axis_tdata = {pres_out_reg, temp_out_reg};
    assign m_axis_tuser = inv_out_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_inv_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:16] == 16'd0)
        else $error("invalid pressure result is not zero");

    a_enter : assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_int_rem : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[FRONT_STAGES + DIV_INT_STEPS - 1]
        && !div_side_reg[DIV_INT_STEPS].ovf && !div_side_reg[DIV_INT_STEPS].inv
        |-> div_rem_reg[DIV_INT_STEPS] < REM_W'(div_den_reg[DIV_INT_STEPS]))
        else $error("divider remainder not reduced after integer steps");

    a_reset : assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
